// ===== hw/rtl/stpq_pkg.sv =====
// Package with the shared types, codes and sizes of the tagged packet queue.
`default_nettype none
package stpq_pkg;

   // Queue storage size and the widths that follow from it.
   localparam int QueueDepth = 256;
   localparam int IdxW       = $clog2(QueueDepth);
   localparam int CntW       = $clog2(QueueDepth + 1);

   // Action codes carried on the request channel.
   localparam logic [2:0] ACT_PUT       = 3'd0;
   localparam logic [2:0] ACT_PUT_FLUSH = 3'd1;
   localparam logic [2:0] ACT_GET       = 3'd2;
   localparam logic [2:0] ACT_FLUSH     = 3'd3;
   localparam logic [2:0] ACT_RESET     = 3'd4;
   localparam logic [2:0] ACT_START     = 3'd5;
   localparam logic [2:0] ACT_ABORT     = 3'd6;

   // Status codes returned with every response.
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_ABORTED = 3'd1;
   localparam logic [2:0] ST_EMPTY   = 3'd2;
   localparam logic [2:0] ST_OVER    = 3'd3;
   localparam logic [2:0] ST_FULL    = 3'd4;

   // Configuration register indexes.
   localparam logic CSR_BYTE_LIMIT   = 1'b0;
   localparam logic CSR_PACKET_LIMIT = 1'b1;

   // Reset values of the configuration registers.
   localparam logic [31:0] BYTE_LIMIT_RST   = 32'd15728640;
   localparam logic [8:0]  PACKET_LIMIT_RST = 9'd255;

   typedef struct packed {
      logic [2:0]  action;
      logic [15:0] pkt_handle;
      logic [23:0] pkt_size;
      logic [31:0] pkt_duration;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] out_handle;
      logic [23:0] out_size;
      logic [31:0] out_duration;
      logic [31:0] out_serial;
      logic        out_is_flush;
      logic [31:0] current_serial;
      logic [8:0]  entry_count;
      logic [39:0] total_duration;
      logic        is_aborted;
   } rsp_type;

   // One queued descriptor as held in the entry store.
   typedef struct packed {
      logic [15:0] handle;
      logic [23:0] size;
      logic        is_flush;
      logic [31:0] duration;
      logic [31:0] serial;
   } entry_type;

   // Write and read requests towards the entry store.
   typedef struct packed {
      logic            wr_en;
      logic [IdxW-1:0] wr_addr;
      logic            rd_en;
      logic [IdxW-1:0] rd_addr;
   } store_ctl_type;

endpackage
`default_nettype wire

// ===== hw/rtl/stpq_store.sv =====
// Descriptor store: one write port and one read port with registered read data.
`default_nettype none
module stpq_store (
   input  wire                        clock,
   input  stpq_pkg::store_ctl_type    ctl,
   input  stpq_pkg::entry_type        wr_data,
   output stpq_pkg::entry_type        rd_data
);
   import stpq_pkg::*;

   entry_type mem [QueueDepth];
   entry_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.wr_addr] <= wr_data;
      end
   end

   // Read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= mem[ctl.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/serial_tagged_packet_queue_unit.sv =====
// Top level of the tagged packet descriptor queue with a generation serial.
//
// Requests arrive on the req_ channel, one action per beat: put, put flush
// marker, get, flush, reset, start or abort. Every request yields exactly one
// response beat on the rsp_ channel carrying the status, the dequeued entry
// on a successful get, and the serial, entry count, total duration and abort
// flag after the action. The byte and packet limits are written through the
// csr_ port, which is ready outside reset; it must be written by the user only
// while the queue is idle, which the block itself does not enforce. A request
// is taken in the IDLE state, which also reads the head entry from the store;
// in the next cycle the execute state runs it and loads the response register
// once that register is free. The request channel stalls outside IDLE, so no
// new request is taken before the last one commits, but a new request is
// taken while an earlier response still waits. When the receiver stalls, the
// response holds and a request in flight waits in the execute state until
// the response register is free. While reset is high the request channel
// stalls. After reset the queue is empty, the serial is zero and the block is
// aborted until a start action; the store contents are not cleared.
`default_nettype none
module serial_tagged_packet_queue_unit (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  stpq_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output stpq_pkg::rsp_type   rsp_data,
   input  wire                 csr_valid,
   output logic                csr_ready,
   input  wire                 csr_index,
   input  wire  [31:0]         csr_data
);
   import stpq_pkg::*;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;
   localparam logic [IdxW-1:0] LastIdx = IdxW'(QueueDepth - 1);
   localparam logic [CntW-1:0] DepthCnt = CntW'(QueueDepth);

   logic            state_ff, state_in;
   req_type         item_ff;
   rsp_type         rsp_ff, rsp_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [31:0]     byte_limit_ff;
   logic [8:0]      packet_limit_ff;
   logic [IdxW-1:0] head_ff, head_in;
   logic [IdxW-1:0] tail_ff, tail_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [32:0]     bytes_ff, bytes_in;
   logic [39:0]     time_ff, time_in;
   logic [31:0]     gen_ff, gen_in;
   logic            abort_ff, abort_in;

   logic            accept;
   logic            commit;
   logic            push_en;
   entry_type       wr_entry;
   entry_type       rd_entry;
   store_ctl_type   store_ctl;
   logic [2:0]      status;
   logic            full;
   logic            over;

   // Handshakes.
   assign accept    = req_valid && !req_stall;
   assign req_stall = reset || (state_ff != S_IDLE);
   assign commit    = (state_ff == S_EXEC) && (!rsp_valid_ff || !rsp_stall);
   assign csr_ready = !reset;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign full = (count_ff >= DepthCnt);
   assign over = (bytes_ff > {1'b0, byte_limit_ff}) ||
                 (32'(count_ff) > 32'(packet_limit_ff));

   // Action execution: next state, store write and response contents.
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      bytes_in = bytes_ff;
      time_in  = time_ff;
      gen_in   = gen_ff;
      abort_in = abort_ff;
      status   = ST_OK;
      push_en  = 1'b0;
      wr_entry = '0;
      rsp_in   = '0;
      case (item_ff.action)
         ACT_PUT: begin
            if (abort_ff) begin
               status = ST_ABORTED;
            end else if (over) begin
               status = ST_OVER;
            end else if (full) begin
               status = ST_FULL;
            end else begin
               push_en           = 1'b1;
               wr_entry.handle   = item_ff.pkt_handle;
               wr_entry.size     = item_ff.pkt_size;
               wr_entry.duration = item_ff.pkt_duration;
            end
         end
         ACT_PUT_FLUSH: begin
            if (abort_ff) begin
               status = ST_ABORTED;
            end else if (full) begin
               status = ST_FULL;
            end else begin
               push_en           = 1'b1;
               wr_entry.is_flush = 1'b1;
            end
         end
         ACT_GET: begin
            if (abort_ff) begin
               status = ST_ABORTED;
            end else if (count_ff == '0) begin
               status = ST_EMPTY;
            end else begin
               rsp_in.out_handle   = rd_entry.handle;
               rsp_in.out_size     = rd_entry.size;
               rsp_in.out_duration = rd_entry.duration;
               rsp_in.out_serial   = rd_entry.serial;
               rsp_in.out_is_flush = rd_entry.is_flush;
               head_in  = (head_ff == LastIdx) ? '0 : head_ff + 1'b1;
               count_in = count_ff - 1'b1;
               bytes_in = bytes_ff - {9'd0, rd_entry.size};
               time_in  = time_ff - {8'd0, rd_entry.duration};
            end
         end
         ACT_FLUSH: begin
            head_in  = '0;
            tail_in  = '0;
            count_in = '0;
            bytes_in = '0;
            time_in  = '0;
         end
         ACT_RESET: begin
            // Cleared queue always has room for the marker.
            head_in           = '0;
            tail_in           = '0;
            count_in          = '0;
            bytes_in          = '0;
            time_in           = '0;
            push_en           = 1'b1;
            wr_entry.is_flush = 1'b1;
         end
         ACT_START: begin
            abort_in = 1'b0;
            if (full) begin
               status = ST_FULL;
            end else begin
               push_en           = 1'b1;
               wr_entry.is_flush = 1'b1;
            end
         end
         ACT_ABORT: begin
            abort_in = 1'b1;
         end
         default: begin
         end
      endcase

      // A marker advances the serial before it is stored with the entry.
      if (push_en && wr_entry.is_flush) begin
         gen_in = gen_ff + 1'b1;
      end
      wr_entry.serial = gen_in;
      if (push_en) begin
         tail_in  = (tail_in == LastIdx) ? '0 : tail_in + 1'b1;
         count_in = count_in + 1'b1;
         bytes_in = bytes_in + {9'd0, wr_entry.size};
         time_in  = time_in + {8'd0, wr_entry.duration};
      end

      rsp_in.status         = status;
      rsp_in.current_serial = gen_in;
      rsp_in.entry_count    = 9'(count_in);
      rsp_in.total_duration = time_in;
      rsp_in.is_aborted     = abort_in;
   end

   // Store accesses: head read on acceptance, entry write on commit.
   always_comb begin
      store_ctl.rd_en   = accept;
      store_ctl.rd_addr = head_ff;
      store_ctl.wr_en   = commit && push_en;
      store_ctl.wr_addr = (item_ff.action == ACT_RESET) ? '0 : tail_ff;
   end

   stpq_store u_store (
      .clock   (clock),
      .ctl     (store_ctl),
      .wr_data (wr_entry),
      .rd_data (rd_entry)
   );

   // Sequencer and response register control.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (commit) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control and queue state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         rsp_valid_ff    <= 1'b0;
         head_ff         <= '0;
         tail_ff         <= '0;
         count_ff        <= '0;
         bytes_ff        <= '0;
         time_ff         <= '0;
         gen_ff          <= '0;
         abort_ff        <= 1'b1;
         byte_limit_ff   <= BYTE_LIMIT_RST;
         packet_limit_ff <= PACKET_LIMIT_RST;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (commit) begin
            head_ff  <= head_in;
            tail_ff  <= tail_in;
            count_ff <= count_in;
            bytes_ff <= bytes_in;
            time_ff  <= time_in;
            gen_ff   <= gen_in;
            abort_ff <= abort_in;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_BYTE_LIMIT:   byte_limit_ff   <= csr_data;
               CSR_PACKET_LIMIT: packet_limit_ff <= csr_data[8:0];
               default: begin
               end
            endcase
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_data;
      end
      if (commit) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for the serial tagged packet descriptor queue.
`timescale 1ns / 1ps

module tb_top;
   import stpq_pkg::*;

   // The one action code that the block must treat as a no-operation.
   localparam logic [2:0] ACT_UNUSED = 3'd7;
   // Cycles without any accepted beat before the run is declared hung.
   localparam int StallLimit = 4000;

   typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX} burst_type;

   // One row of the directed table; want is used only when typed is set.
   typedef struct {
      req_type req;
      bit      typed;
      rsp_type want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = 1'b0;
   logic [31:0] csr_data = '0;

   int           err_count = 0;
   int           send_pct = 0;
   int           recv_pct = 0;
   int           quiet_cycles = 0;
   rsp_type      rsp_expected[$];
   stim_row_type dir_tab[$];

   // Shadow copy of the queue contents, counters and limits.
   logic [15:0]          q_handle [QueueDepth];
   logic [23:0]          q_size   [QueueDepth];
   logic                 q_flush  [QueueDepth];
   logic [31:0]          q_dur    [QueueDepth];
   logic [31:0]          q_serial [QueueDepth];
   logic [IdxW-1:0]      q_head, q_tail;
   logic [8:0]           q_count;
   logic [32:0]          q_bytes;
   logic [39:0]          q_time;
   logic [31:0]          q_gen;
   logic                 q_abort;
   logic [31:0]          lim_bytes;
   logic [8:0]           lim_pkts;

   serial_tagged_packet_queue_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Receiver back-pressure, redrawn every cycle.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_pct);
   end

   function automatic void queue_clear_all();
      q_head  = '0;
      q_tail  = '0;
      q_count = '0;
      q_bytes = '0;
      q_time  = '0;
   endfunction

   function automatic void enqueue_desc(logic [15:0] h, logic [23:0] s, logic [31:0] d,
                                        logic flush);
      q_handle[q_tail] = h;
      q_size[q_tail]   = s;
      q_flush[q_tail]  = flush;
      q_dur[q_tail]    = d;
      q_serial[q_tail] = q_gen;
      q_tail  = q_tail + 1'b1;
      q_count = q_count + 1'b1;
      q_bytes = q_bytes + {9'd0, s};
      q_time  = q_time + {8'd0, d};
   endfunction

   // A marker advances the serial only when there is room for it.
   function automatic logic [2:0] queue_marker();
      if (q_count >= QueueDepth) return ST_FULL;
      q_gen = q_gen + 1'b1;
      enqueue_desc('0, '0, '0, 1'b1);
      return ST_OK;
   endfunction

   // Applies one action to the shadow queue and returns the response it yields.
   function automatic rsp_type queue_step(req_type r);
      rsp_type o;
      o = '0;
      o.status = ST_OK;
      case (r.action)
         ACT_PUT: begin
            if (q_abort) o.status = ST_ABORTED;
            else if (q_bytes > {1'b0, lim_bytes} || q_count > lim_pkts) o.status = ST_OVER;
            else if (q_count >= QueueDepth) o.status = ST_FULL;
            else enqueue_desc(r.pkt_handle, r.pkt_size, r.pkt_duration, 1'b0);
         end
         ACT_PUT_FLUSH: begin
            if (q_abort) o.status = ST_ABORTED;
            else o.status = queue_marker();
         end
         ACT_GET: begin
            if (q_abort) o.status = ST_ABORTED;
            else if (q_count == 0) o.status = ST_EMPTY;
            else begin
               o.out_handle   = q_handle[q_head];
               o.out_size     = q_size[q_head];
               o.out_is_flush = q_flush[q_head];
               o.out_duration = q_dur[q_head];
               o.out_serial   = q_serial[q_head];
               q_head  = q_head + 1'b1;
               q_count = q_count - 1'b1;
               q_bytes = q_bytes - {9'd0, o.out_size};
               q_time  = q_time - {8'd0, o.out_duration};
            end
         end
         ACT_FLUSH: queue_clear_all();
         ACT_RESET: begin
            queue_clear_all();
            o.status = queue_marker();
         end
         ACT_START: begin
            q_abort  = 1'b0;
            o.status = queue_marker();
         end
         ACT_ABORT: q_abort = 1'b1;
         default: ;
      endcase
      o.current_serial = q_gen;
      o.entry_count    = q_count;
      o.total_duration = q_time;
      o.is_aborted     = q_abort;
      return o;
   endfunction

   function automatic void add_row(req_type r, bit typed, rsp_type want);
      stim_row_type row;
      row.req   = r;
      row.typed = typed;
      row.want  = want;
      dir_tab.insert(dir_tab.size(), row);
   endfunction

   // Mostly small values, with full-range and all-zero or all-one words mixed in.
   function automatic logic [31:0] rand_word();
      case ($urandom_range(3))
         0, 1: return $urandom_range(4095);
         2: return $urandom;
         default: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
      endcase
   endfunction

   // Draws one action, leaning towards puts or gets according to the burst.
   function automatic req_type pick_item(burst_type kind);
      req_type r;
      int      roll;
      r.pkt_handle   = 16'($urandom);
      r.pkt_size     = 24'(rand_word());
      r.pkt_duration = rand_word();
      roll = $urandom_range(99);
      if (q_abort && $urandom_range(99) < 60) r.action = ACT_START;
      else if (kind == MODE_FILL)
         r.action = (roll < 92) ? ACT_PUT : (roll < 97) ? ACT_PUT_FLUSH : ACT_GET;
      else if (kind == MODE_DRAIN && roll < 80) r.action = ACT_GET;
      else if (kind == MODE_DRAIN && roll < 88) r.action = ACT_PUT;
      else if (kind == MODE_DRAIN && roll < 92) r.action = ACT_PUT_FLUSH;
      else if (kind == MODE_MIX && roll < 45) r.action = ACT_PUT;
      else if (kind == MODE_MIX && roll < 85) r.action = ACT_GET;
      else if (kind == MODE_MIX && roll < 90) r.action = ACT_PUT_FLUSH;
      else begin
         case ($urandom_range(4))
            0: r.action = ACT_FLUSH;
            1: r.action = ACT_RESET;
            2: r.action = ACT_START;
            3: r.action = ACT_ABORT;
            default: r.action = ACT_UNUSED;
         endcase
      end
      return r;
   endfunction

   // Offers one request beat after a random gap and records what it must return.
   task automatic send_item(req_type r, bit typed, rsp_type want);
      rsp_type pred;
      while ($urandom_range(99) < send_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall !== 1'b0);
      pred = queue_step(r);
      rsp_expected.insert(rsp_expected.size(), typed ? want : pred);
   endtask

   task automatic write_csr(logic idx, logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      if (idx == CSR_BYTE_LIMIT) lim_bytes = val;
      else lim_pkts = val[8:0];
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (rsp_expected.size() != 0) @(posedge clock);
   endtask

   // One phase: settle, optionally reprogram the limits, then fill and mixed bursts.
   task automatic run_phase(bit write_cfg, logic [31:0] bytes_lim, logic [8:0] pkts_lim,
                            int s_pct, int r_pct, int fill_items, int mix_items);
      int        left;
      int        burst;
      burst_type kind;
      wait_drained();
      repeat (4) @(posedge clock);
      if (write_cfg) begin
         write_csr(CSR_BYTE_LIMIT, bytes_lim);
         write_csr(CSR_PACKET_LIMIT, {23'd0, pkts_lim});
      end
      send_pct = s_pct;
      recv_pct = r_pct;
      for (int i = 0; i < fill_items; i++) send_item(pick_item(MODE_FILL), 1'b0, '0);
      left = mix_items;
      while (left > 0) begin
         kind  = burst_type'($urandom_range(2));
         burst = $urandom_range(8, 40);
         if (burst > left) burst = left;
         for (int i = 0; i < burst; i++) send_item(pick_item(kind), 1'b0, '0);
         left -= burst;
      end
      req_valid <= 1'b0;
   endtask

   function automatic void check_field(string fname, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", fname, want, got);
         err_count++;
      end
   endfunction

   // Compare every response beat with the oldest outstanding prediction.
   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rsp_expected.size() == 0) begin
            $error("response beat with no request outstanding");
            err_count++;
         end else begin
            want = rsp_expected[0];
            rsp_expected.delete(0);
            check_field("status", 64'(want.status), 64'(rsp_data.status));
            check_field("out_handle", 64'(want.out_handle), 64'(rsp_data.out_handle));
            check_field("out_size", 64'(want.out_size), 64'(rsp_data.out_size));
            check_field("out_duration", 64'(want.out_duration),
                        64'(rsp_data.out_duration));
            check_field("out_serial", 64'(want.out_serial), 64'(rsp_data.out_serial));
            check_field("out_is_flush", 64'(want.out_is_flush),
                        64'(rsp_data.out_is_flush));
            check_field("current_serial", 64'(want.current_serial),
                        64'(rsp_data.current_serial));
            check_field("entry_count", 64'(want.entry_count), 64'(rsp_data.entry_count));
            check_field("total_duration", 64'(want.total_duration),
                        64'(rsp_data.total_duration));
            check_field("is_aborted", 64'(want.is_aborted), 64'(rsp_data.is_aborted));
         end
      end
   end

   // Hang detection: any accepted beat on any channel restarts the count.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      queue_clear_all();
      q_gen     = '0;
      q_abort   = 1'b1;
      lim_bytes = BYTE_LIMIT_RST;
      lim_pkts  = PACKET_LIMIT_RST;

      // Directed table: refusals while aborted, start and marker, extremes, limits.
      add_row('{ACT_PUT, 16'hFFFF, 24'hFF_FFFF, 32'hFFFF_FFFF}, 1'b1,
              '{ST_ABORTED, 16'h0, 24'h0, 32'h0, 32'h0, 1'b0, 32'd0, 9'd0, 40'd0, 1'b1});
      add_row('{ACT_GET, 16'h0, 24'h0, 32'h0}, 1'b1,
              '{ST_ABORTED, 16'h0, 24'h0, 32'h0, 32'h0, 1'b0, 32'd0, 9'd0, 40'd0, 1'b1});
      add_row('{ACT_PUT_FLUSH, 16'h0, 24'h0, 32'h0}, 1'b1,
              '{ST_ABORTED, 16'h0, 24'h0, 32'h0, 32'h0, 1'b0, 32'd0, 9'd0, 40'd0, 1'b1});
      add_row('{ACT_UNUSED, 16'h1234, 24'h12_3456, 32'h1234_5678}, 1'b1,
              '{ST_OK, 16'h0, 24'h0, 32'h0, 32'h0, 1'b0, 32'd0, 9'd0, 40'd0, 1'b1});
      add_row('{ACT_ABORT, 16'h0, 24'h0, 32'h0}, 1'b1,
              '{ST_OK, 16'h0, 24'h0, 32'h0, 32'h0, 1'b0, 32'd0, 9'd0, 40'd0, 1'b1});
      add_row('{ACT_FLUSH, 16'h0, 24'h0, 32'h0}, 1'b1,
              '{ST_OK, 16'h0, 24'h0, 32'h0, 32'h0, 1'b0, 32'd0, 9'd0, 40'd0, 1'b1});
      add_row('{ACT_START, 16'h0, 24'h0, 32'h0}, 1'b1,
              '{ST_OK, 16'h0, 24'h0, 32'h0, 32'h0, 1'b0, 32'd1, 9'd1, 40'd0, 1'b0});
      add_row('{ACT_GET, 16'h0, 24'h0, 32'h0}, 1'b1,
              '{ST_OK, 16'h0, 24'h0, 32'h0, 32'd1, 1'b1, 32'd1, 9'd0, 40'd0, 1'b0});
      add_row('{ACT_GET, 16'h0, 24'h0, 32'h0}, 1'b1,
              '{ST_EMPTY, 16'h0, 24'h0, 32'h0, 32'h0, 1'b0, 32'd1, 9'd0, 40'd0, 1'b0});
      add_row('{ACT_PUT, 16'h0, 24'h0, 32'h0}, 1'b0, '0);
      add_row('{ACT_PUT, 16'hFFFF, 24'hFF_FFFF, 32'hFFFF_FFFF}, 1'b0, '0);
      // The byte total now exceeds the default limit, so this put is refused.
      add_row('{ACT_PUT, 16'h1234, 24'h100, 32'h100}, 1'b0, '0);
      // Markers ignore the limits.
      add_row('{ACT_PUT_FLUSH, 16'hFFFF, 24'hFF_FFFF, 32'hFFFF_FFFF}, 1'b0, '0);
      add_row('{ACT_GET, 16'h0, 24'h0, 32'h0}, 1'b0, '0);
      add_row('{ACT_GET, 16'h0, 24'h0, 32'h0}, 1'b0, '0);
      add_row('{ACT_GET, 16'h0, 24'h0, 32'h0}, 1'b0, '0);
      add_row('{ACT_PUT, 16'hAAAA, 24'h55_5555, 32'hAAAA_AAAA}, 1'b0, '0);
      add_row('{ACT_PUT, 16'h5555, 24'hAA_AAAA, 32'h5555_5555}, 1'b0, '0);
      // Abort with entries queued; a get is then refused although data waits.
      add_row('{ACT_ABORT, 16'h0, 24'h0, 32'h0}, 1'b0, '0);
      add_row('{ACT_GET, 16'h0, 24'h0, 32'h0}, 1'b0, '0);
      add_row('{ACT_START, 16'h0, 24'h0, 32'h0}, 1'b0, '0);
      add_row('{ACT_RESET, 16'h0, 24'h0, 32'h0}, 1'b0, '0);
      add_row('{ACT_PUT, 16'h0F0F, 24'hF0_F0F0, 32'h0F0F_0F0F}, 1'b0, '0);
      add_row('{ACT_FLUSH, 16'h0, 24'h0, 32'h0}, 1'b0, '0);
      add_row('{ACT_GET, 16'h0, 24'h0, 32'h0}, 1'b0, '0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (dir_tab[i]) send_item(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].want);
      req_valid <= 1'b0;

      // Random phases over several limit settings and back-pressure patterns.
      run_phase(1'b0, '0, '0, 0, 0, 0, 120);
      run_phase(1'b1, 32'hFFFF_FFFF, 9'd256, 87, 0, 320, 20);
      run_phase(1'b1, 32'h0, 9'd0, 0, 87, 0, 100);
      run_phase(1'b1, $urandom, 9'($urandom_range(256)), 32, 32, 0, 120);
      run_phase(1'b1, 32'd20000, 9'd16, 0, 0, 40, 20);

      wait_drained();
      repeat (8) @(posedge clock);
      if (err_count == 0 && rsp_expected.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/stpq_pkg.sv
hw/rtl/stpq_store.sv
hw/rtl/serial_tagged_packet_queue_unit.sv
test/tb_top.sv
